// File: design/lrmc_pkg.sv
package lrmc_pkg;

    // Window / payload defaults
    localparam int WINDOW_DEF        = 250;
    localparam int PAYLOAD_BYTES_DEF = 320;

    // Fixed field widths
    localparam int PCT_W      = 7;
    localparam int BYTES_W    = 31;
    localparam int LOSS_W     = 8;
    localparam int FRAME_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Percent scale for the loss compare
    localparam int PCT_FULL = 100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP_ONE_TWO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TWO_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_TWO_THREE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THREE_TWO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_ONE_BYTES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_TWO_BYTES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_THREE_BYTES = 3'd6;

    // Register reset values
    localparam logic [PCT_W-1:0] UP_ONE_TWO_RST     = 7'd15;
    localparam logic [PCT_W-1:0] DOWN_TWO_ONE_RST   = 7'd10;
    localparam logic [PCT_W-1:0] UP_TWO_THREE_RST   = 7'd30;
    localparam logic [PCT_W-1:0] DOWN_THREE_TWO_RST = 7'd25;

    typedef enum logic [1:0] {
        MODE_ONE   = 2'd1,
        MODE_TWO   = 2'd2,
        MODE_THREE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [BYTES_W-1:0] one;
        logic [BYTES_W-1:0] two;
        logic [BYTES_W-1:0] three;
    } t_frame_limits;

endpackage

// File: design/lrmc_cell.sv
module lrmc_cell
    import lrmc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_bit,
    output logic o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: design/lrmc_window.sv
module lrmc_window
    import lrmc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int SUM_W = $clog2(WINDOW + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_bit,
    output logic [SUM_W-1:0] o_sum_next
);

    // w_chain[k] feeds cell k; the last tap is the outcome leaving the window
    logic [WINDOW:0]  w_chain;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    assign w_chain[0] = i_bit;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        lrmc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_bit   (w_chain[k]),
            .o_bit   (w_chain[k+1])
        );
    end

    assign n_sum = r_sum - SUM_W'(w_chain[WINDOW]) + SUM_W'(i_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_next = n_sum;

endmodule

// File: design/lrmc_frame.sv
module lrmc_frame
    import lrmc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_mode              i_mode,
    input  t_frame_limits      i_limits,
    output logic [FRAME_W-1:0] o_frame_next
);

    localparam int STRIDE_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int PROD_W   = FRAME_W + STRIDE_W;
    localparam int CMP_W    = (PROD_W > BYTES_W) ? PROD_W : BYTES_W;

    localparam logic [PROD_W-1:0] STRIDE_ONE   = PROD_W'(PAYLOAD_BYTES);
    localparam logic [PROD_W-1:0] STRIDE_TWO   = PROD_W'(PAYLOAD_BYTES / 2);
    localparam logic [PROD_W-1:0] STRIDE_THREE = PROD_W'(PAYLOAD_BYTES / 4);

    // r_off_* track (frame + 1) * stride for each mode, so no multiplier
    logic [FRAME_W-1:0] r_frame;
    logic [PROD_W-1:0]  r_off_one, r_off_two, r_off_three;
    logic [PROD_W-1:0]  w_off;
    logic [BYTES_W-1:0] w_limit;
    logic               w_wrap;
    logic [FRAME_W-1:0] n_frame;

    always_comb begin
        unique case (i_mode)
            MODE_TWO: begin
                w_off   = r_off_two;
                w_limit = i_limits.two;
            end
            MODE_THREE: begin
                w_off   = r_off_three;
                w_limit = i_limits.three;
            end
            default: begin
                w_off   = r_off_one;
                w_limit = i_limits.one;
            end
        endcase
    end

    // counter at its top wraps like a 25-bit register
    assign w_wrap  = (CMP_W'(w_off) >= CMP_W'(w_limit)) || (r_frame == '1);
    assign n_frame = w_wrap ? '0 : r_frame + FRAME_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_off_one   <= STRIDE_ONE;
            r_off_two   <= STRIDE_TWO;
            r_off_three <= STRIDE_THREE;
        end else if (i_advance) begin
            r_frame <= n_frame;
            if (w_wrap) begin
                r_off_one   <= STRIDE_ONE;
                r_off_two   <= STRIDE_TWO;
                r_off_three <= STRIDE_THREE;
            end else begin
                r_off_one   <= r_off_one + STRIDE_ONE;
                r_off_two   <= r_off_two + STRIDE_TWO;
                r_off_three <= r_off_three + STRIDE_THREE;
            end
        end
    end

    assign o_frame_next = n_frame;

endmodule

// File: design/loss_rate_mode_controller.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_packet_lost
// out      | output    | o_out_valid / i_out_ready  | o_loss_count, o_next_mode,
//          |           |                            | o_next_frame
// cfg      | input     | i_cfg_wr_en (no wait)      | i_cfg_idx, i_cfg_data
//
// One item per cycle while the output is not stalled; the result is registered at the
// accept edge, valid the next cycle. Window, running sum, mode and frame counter all
// update at that edge, so items can follow back to back.
// Reset (synchronous, active low) clears every history cell, sum, frame and output valid;
// mode returns to 1 and the thresholds to their defaults.
// A stalled output holds its item; input is taken while the output is empty or draining.
module loss_rate_mode_controller
    import lrmc_pkg::*;
#(
    parameter int WINDOW        = WINDOW_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // packet outcomes
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_packet_lost,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LOSS_W-1:0]     o_loss_count,
    output logic [1:0]            o_next_mode,
    output logic [FRAME_W-1:0]    o_next_frame,
    // register writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = $clog2(WINDOW + 1);
    // sum*100 and pct*WINDOW both stay below 2^(SUM_W+7)
    localparam int CMP_W = SUM_W + PCT_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [PCT_W-1:0] r_up_one_two;
    logic [PCT_W-1:0] r_down_two_one;
    logic [PCT_W-1:0] r_up_two_three;
    logic [PCT_W-1:0] r_down_three_two;
    t_frame_limits    r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_one_two     <= UP_ONE_TWO_RST;
            r_down_two_one   <= DOWN_TWO_ONE_RST;
            r_up_two_three   <= UP_TWO_THREE_RST;
            r_down_three_two <= DOWN_THREE_TWO_RST;
            r_limits         <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_UP_ONE_TWO:       r_up_one_two     <= i_cfg_data[PCT_W-1:0];
                CFG_DOWN_TWO_ONE:     r_down_two_one   <= i_cfg_data[PCT_W-1:0];
                CFG_UP_TWO_THREE:     r_up_two_three   <= i_cfg_data[PCT_W-1:0];
                CFG_DOWN_THREE_TWO:   r_down_three_two <= i_cfg_data[PCT_W-1:0];
                CFG_MODE_ONE_BYTES:   r_limits.one     <= i_cfg_data[BYTES_W-1:0];
                CFG_MODE_TWO_BYTES:   r_limits.two     <= i_cfg_data[BYTES_W-1:0];
                CFG_MODE_THREE_BYTES: r_limits.three   <= i_cfg_data[BYTES_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic w_in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------
    // Loss window: one cell per outcome, shifting on each accepted item
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] w_sum_next;

    lrmc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (w_in_fire),
        .i_bit      (i_packet_lost),
        .o_sum_next (w_sum_next)
    );

    // ---------------------------------------------------------------
    // Mode state with hysteresis; loss% vs pct done as sum*100 vs pct*WINDOW
    // ---------------------------------------------------------------
    t_mode            r_mode;
    t_mode            n_mode;
    logic [CMP_W-1:0] w_loss_scaled;

    assign w_loss_scaled = CMP_W'(w_sum_next) * CMP_W'(PCT_FULL);

    function automatic logic [CMP_W-1:0] pct_scaled(input logic [PCT_W-1:0] pct);
        return CMP_W'(pct) * CMP_W'(WINDOW);
    endfunction

    always_comb begin
        unique case (r_mode)
            MODE_TWO: begin
                if (w_loss_scaled <= pct_scaled(r_down_two_one)) begin
                    n_mode = MODE_ONE;
                end else if (w_loss_scaled >= pct_scaled(r_up_two_three)) begin
                    n_mode = MODE_THREE;
                end else begin
                    n_mode = MODE_TWO;
                end
            end
            MODE_THREE: begin
                n_mode = (w_loss_scaled <= pct_scaled(r_down_three_two)) ? MODE_TWO
                                                                          : MODE_THREE;
            end
            default: begin
                n_mode = (w_loss_scaled >= pct_scaled(r_up_one_two)) ? MODE_TWO : MODE_ONE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Frame counter, stepped with the mode in force for this item
    // ---------------------------------------------------------------
    logic [FRAME_W-1:0] w_frame_next;

    lrmc_frame #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_in_fire),
        .i_mode       (r_mode),
        .i_limits     (r_limits),
        .o_frame_next (w_frame_next)
    );

    // ---------------------------------------------------------------
    // State and output register
    // ---------------------------------------------------------------
    logic [LOSS_W-1:0]  r_loss_count;
    t_mode              r_next_mode;
    logic [FRAME_W-1:0] r_next_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ONE;
            r_out_valid  <= 1'b0;
            r_loss_count <= '0;
            r_next_mode  <= MODE_ONE;
            r_next_frame <= '0;
        end else begin
            if (w_in_fire) begin
                r_mode       <= n_mode;
                r_loss_count <= LOSS_W'(w_sum_next);
                r_next_mode  <= n_mode;
                r_next_frame <= w_frame_next;
            end
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_loss_count = r_loss_count;
    assign o_next_mode  = r_next_mode;
    assign o_next_frame = r_next_frame;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_out_valid)
        else $error("accepted item left no result");

    a_no_mode_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && r_mode == MODE_ONE) |=> (r_mode != MODE_THREE))
        else $error("mode jumped from 1 to 3");

    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum_next <= SUM_W'(WINDOW))
        else $error("loss sum exceeds window");

endmodule
